@@ rtl/core/rgb_to_hsv_converter_assert.svh @@
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Immediate-consequence and next-cycle forms, both clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

`define RGB2HSV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define RGB2HSV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/rgb2hsv_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Field widths, hue constants and pipeline stage types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgb2hsv_pkg;

   localparam int COMP_W     = 8;
   localparam int HUE_W      = 15;
   localparam int SAT_QUO_W  = 8;
   localparam int HUE_QUO_W  = 12;
   localparam int SAT_REM_W  = 16;
   localparam int HUE_REM_W  = 20;

   localparam logic [SAT_REM_W-1:0] SAT_SCALE     = 16'd255;
   localparam logic [HUE_REM_W-1:0] HUE_SIXTH     = 20'd3840;
   localparam logic [HUE_W-1:0]     HUE_GREEN_OFF = 15'd7680;
   localparam logic [HUE_W-1:0]     HUE_BLUE_OFF  = 15'd15360;
   localparam logic [HUE_W-1:0]     HUE_FULL      = 15'd23040;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic [COMP_W-1:0] brightness;
      logic [COMP_W-1:0] delta;
      sector_type        sector;
      logic              diff_neg;
      logic [COMP_W-1:0] diff_mag;
   } front_type;

   typedef struct packed {
      logic [COMP_W-1:0]    brightness;
      logic [COMP_W-1:0]    delta;
      sector_type           sector;
      logic                 diff_neg;
      logic [SAT_REM_W-1:0] sat_rem;
      logic [SAT_QUO_W-1:0] sat_quo;
      logic [HUE_REM_W-1:0] hue_rem;
      logic [HUE_QUO_W-1:0] hue_quo;
   } div_stage_type;

endpackage

`default_nettype wire

@@ rtl/core/rgb2hsv_if.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV converter channels
// Valid/ready channels for the pixel request and the HSV response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rgb2hsv_req_if;
   import rgb2hsv_pkg::*;

   logic              valid;
   logic              ready;
   logic [COMP_W-1:0] red;
   logic [COMP_W-1:0] green;
   logic [COMP_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgb2hsv_rsp_if;
   import rgb2hsv_pkg::*;

   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [COMP_W-1:0] saturation;
   logic [COMP_W-1:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/core/rgb_to_hsv_converter.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Pipelined conversion of 8-bit RGB pixels to hue (1/64 degree),
// saturation and brightness, with two one-bit-per-stage dividers.
// ----------------------------------------------------------------------------
//   channel   dir  payload                          handshake
//   req_chan  in   red, green, blue                 valid/ready
//   rsp_chan  out  hue, saturation, brightness      valid/ready
//
// One item per cycle sustained while the response channel is not stalled;
// 16 register stages, set by the 12-stage hue divider (one quotient bit per
// stage) plus input, front, numerator and output registers.
// Synchronous reset clears all stage valid bits.
// Each stage holds while its successor is full and stalled; bubbles close up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter (
   input  logic          clock,
   input  logic          reset,
   rgb2hsv_req_if.sink   req_chan,
   rgb2hsv_rsp_if.source rsp_chan
);
   import rgb2hsv_pkg::*;

   localparam int STEPS = HUE_QUO_W;

   logic [COMP_W-1:0] red_ff, green_ff, blue_ff;
   logic              in_v_ff;
   front_type         front_ff, front_in;
   logic              front_v_ff;
   div_stage_type     num_ff, num_in;
   logic              num_v_ff;
   div_stage_type     div_ff [STEPS];
   div_stage_type     div_in [STEPS];
   logic              div_v_ff [STEPS];
   logic              en_div [STEPS];
   logic [HUE_W-1:0]  hue_ff, hue_in;
   logic [COMP_W-1:0] sat_ff, sat_in;
   logic [COMP_W-1:0] bright_ff;
   logic              out_v_ff;
   logic              en_out, en_num, en_front, en_in;

   // handshake chain
   assign en_out   = !out_v_ff || rsp_chan.ready;
   assign en_num   = !num_v_ff || en_div[0];
   assign en_front = !front_v_ff || en_num;
   assign en_in    = !in_v_ff || en_front;
   assign req_chan.ready = en_in;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en_in) begin
         in_v_ff <= req_chan.valid;
      end
      if (en_in) begin
         red_ff   <= req_chan.red;
         green_ff <= req_chan.green;
         blue_ff  <= req_chan.blue;
      end
   end

   // max, min, sector and hue difference
   always_comb begin
      logic [COMP_W-1:0] mx, mn, pa, pb;
      mx = (red_ff > green_ff) ? red_ff : green_ff;
      mx = (mx > blue_ff) ? mx : blue_ff;
      mn = (red_ff < green_ff) ? red_ff : green_ff;
      mn = (mn < blue_ff) ? mn : blue_ff;
      if (red_ff >= mx) begin
         front_in.sector = SECTOR_RED;
         pa = green_ff;
         pb = blue_ff;
      end else if (green_ff >= mx) begin
         front_in.sector = SECTOR_GREEN;
         pa = blue_ff;
         pb = red_ff;
      end else begin
         front_in.sector = SECTOR_BLUE;
         pa = red_ff;
         pb = green_ff;
      end
      front_in.brightness = mx;
      front_in.delta      = mx - mn;
      front_in.diff_neg   = pa < pb;
      front_in.diff_mag   = (pa < pb) ? (pb - pa) : (pa - pb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else if (en_front) begin
         front_v_ff <= in_v_ff;
      end
      if (en_front) begin
         front_ff <= front_in;
      end
   end

   // divider numerators
   always_comb begin
      num_in.brightness = front_ff.brightness;
      num_in.delta      = front_ff.delta;
      num_in.sector     = front_ff.sector;
      num_in.diff_neg   = front_ff.diff_neg;
      num_in.sat_rem    = SAT_REM_W'(front_ff.delta) * SAT_SCALE;
      num_in.sat_quo    = '0;
      num_in.hue_rem    = HUE_REM_W'(front_ff.diff_mag) * HUE_SIXTH;
      num_in.hue_quo    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_v_ff <= 1'b0;
      end else if (en_num) begin
         num_v_ff <= front_v_ff;
      end
      if (en_num) begin
         num_ff <= num_in;
      end
   end

   // divider stages: one hue bit each, saturation bits in the early stages
   for (genvar k = 0; k < STEPS; k++) begin : g_div
      localparam int SAT_SH = (k < SAT_QUO_W) ? (SAT_QUO_W - 1 - k) : 0;

      div_stage_type prev;
      logic          prev_v;

      if (k == 0) begin : g_head
         assign prev   = num_ff;
         assign prev_v = num_v_ff;
      end else begin : g_body
         assign prev   = div_ff[k-1];
         assign prev_v = div_v_ff[k-1];
      end

      if (k == STEPS - 1) begin : g_last
         assign en_div[k] = !div_v_ff[k] || en_out;
      end else begin : g_mid
         assign en_div[k] = !div_v_ff[k] || en_div[k+1];
      end

      always_comb begin
         logic [HUE_REM_W-1:0] hue_dsh;
         logic [SAT_REM_W-1:0] sat_dsh;
         hue_dsh    = HUE_REM_W'(prev.delta) << (HUE_QUO_W - 1 - k);
         sat_dsh    = SAT_REM_W'(prev.brightness) << SAT_SH;
         div_in[k]  = prev;
         if (prev.hue_rem >= hue_dsh) begin
            div_in[k].hue_rem                   = prev.hue_rem - hue_dsh;
            div_in[k].hue_quo[HUE_QUO_W - 1 - k] = 1'b1;
         end
         if (k < SAT_QUO_W) begin
            if (prev.sat_rem >= sat_dsh) begin
               div_in[k].sat_rem         = prev.sat_rem - sat_dsh;
               div_in[k].sat_quo[SAT_SH] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_v_ff[k] <= 1'b0;
         end else if (en_div[k]) begin
            div_v_ff[k] <= prev_v;
         end
         if (en_div[k]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // sector offset, sign and wrap
   always_comb begin
      div_stage_type      d;
      logic [HUE_W-1:0]   off;
      logic [HUE_W:0]     q;
      logic [HUE_W:0]     sum;
      d = div_ff[STEPS-1];
      q = (HUE_W + 1)'(d.hue_quo);
      case (d.sector)
         SECTOR_RED:   off = '0;
         SECTOR_GREEN: off = HUE_GREEN_OFF;
         SECTOR_BLUE:  off = HUE_BLUE_OFF;
         default:      off = '0;
      endcase
      if (!d.diff_neg) begin
         sum = (HUE_W + 1)'(off) + q;
      end else if ((HUE_W + 1)'(off) >= q) begin
         sum = (HUE_W + 1)'(off) - q;
      end else begin
         sum = (HUE_W + 1)'(off) + (HUE_W + 1)'(HUE_FULL) - q;
      end
      if (sum >= (HUE_W + 1)'(HUE_FULL)) begin
         sum = sum - (HUE_W + 1)'(HUE_FULL);
      end
      hue_in = (d.delta == '0) ? '0 : sum[HUE_W-1:0];
      sat_in = (d.brightness == '0) ? '0 : d.sat_quo;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en_out) begin
         out_v_ff <= div_v_ff[STEPS-1];
      end
      if (en_out) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= div_ff[STEPS-1].brightness;
      end
   end

   assign rsp_chan.valid      = out_v_ff;
   assign rsp_chan.hue        = hue_ff;
   assign rsp_chan.saturation = sat_ff;
   assign rsp_chan.brightness = bright_ff;

endmodule

`default_nettype wire

@@ rtl/core/rgb2hsv_checker.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV converter checker
// Port-level checks on the response and request channels, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_to_hsv_converter_assert.svh"

module rgb2hsv_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rgb2hsv_pkg::HUE_W-1:0]  hue,
   input logic [rgb2hsv_pkg::COMP_W-1:0] saturation,
   input logic [rgb2hsv_pkg::COMP_W-1:0] brightness
);
   import rgb2hsv_pkg::*;

   `RGB2HSV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(hue) && $stable(saturation) && $stable(brightness), "response item changed while stalled")

   `RGB2HSV_ASSERT_NOW(a_hue_range, rsp_valid, hue < HUE_FULL, "hue beyond full turn")

   `RGB2HSV_ASSERT_NOW(a_hue_needs_sat, rsp_valid && hue != '0, saturation != '0 && brightness != '0, "hue on a gray or black pixel")

   `RGB2HSV_ASSERT_NOW(a_ready_passes, rsp_ready, req_ready, "request stalled while response drains")

   `RGB2HSV_ASSERT_NOW(a_reset_empty, $fell(reset), !rsp_valid, "response item present after reset")

endmodule

bind rgb_to_hsv_converter rgb2hsv_checker u_rgb2hsv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .hue        (rsp_chan.hue),
   .saturation (rsp_chan.saturation),
   .brightness (rsp_chan.brightness)
);

`default_nettype wire

@@ dv/rgb_to_hsv_converter_tb.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Offers 8-bit RGB pixels on the request channel and compares every HSV
// item on the response channel, in order, against fixed values or an
// integer model of the conversion. A short directed table covers black,
// white, gray, the pure primaries and secondaries, sector ties and
// truncation of negative hues. A random stream follows with grays, ties,
// small spreads and extreme components mixed in. The sender works in
// bursts with gaps. The receiver stalls on a shifting pattern and once
// holds off long enough to fill the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_hsv_converter_tb;
   import rgb2hsv_pkg::*;

   localparam int RANDOM_PIXELS = 500;
   localparam int PIPE_LATENCY  = 16;
   localparam int HOLD_AT       = 150;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [COMP_W-1:0] saturation;
      logic [COMP_W-1:0] brightness;
   } hsv_type;

   typedef struct packed {
      pixel_type px;
      logic      typed;
      hsv_type   golden;
   } directed_row_type;

   logic clock;
   logic reset;

   rgb2hsv_req_if req_if ();
   rgb2hsv_rsp_if rsp_if ();

   rgb_to_hsv_converter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   hsv_type expected_hsv[$];
   int      mismatches = 0;
   int      burst_left = 0;
   int      cycle_count = 0;

   // receiver state
   logic [15:0] stall_pattern = 16'hffff;
   int          pattern_left = 32;
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   int          pixels_taken = 0;

   directed_row_type directed_rows [0:18] = '{
      '{'{8'd0,   8'd0,   8'd0},   1'b1, '{15'd0,     8'd0,   8'd0}},
      '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{15'd0,     8'd0,   8'd255}},
      '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{15'd0,     8'd0,   8'd128}},
      '{'{8'd255, 8'd0,   8'd0},   1'b1, '{15'd0,     8'd255, 8'd255}},
      '{'{8'd0,   8'd255, 8'd0},   1'b1, '{15'd7680,  8'd255, 8'd255}},
      '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{15'd15360, 8'd255, 8'd255}},
      '{'{8'd255, 8'd255, 8'd0},   1'b1, '{15'd3840,  8'd255, 8'd255}},
      '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{15'd19200, 8'd255, 8'd255}},
      '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{15'd11520, 8'd255, 8'd255}},
      '{'{8'd1,   8'd0,   8'd0},   1'b1, '{15'd0,     8'd255, 8'd1}},
      '{'{8'd0,   8'd0,   8'd1},   1'b1, '{15'd15360, 8'd255, 8'd1}},
      '{'{8'd255, 8'd0,   8'd1},   1'b0, '0},
      '{'{8'd254, 8'd255, 8'd0},   1'b0, '0},
      '{'{8'd200, 8'd100, 8'd50},  1'b0, '0},
      '{'{8'd1,   8'd2,   8'd3},   1'b0, '0},
      '{'{8'd128, 8'd127, 8'd127}, 1'b0, '0},
      '{'{8'd0,   8'd200, 8'd200}, 1'b0, '0},
      '{'{8'd170, 8'd85,  8'd255}, 1'b0, '0},
      '{'{8'd255, 8'd254, 8'd255}, 1'b0, '0}
   };

   always #5 clock = ~clock;

   function automatic hsv_type hsv_of(input pixel_type px);
      int top;
      int bottom;
      int spread;
      int slope;
      int base;
      int angle;
      hsv_type res;
      top    = px.red;
      bottom = px.red;
      if (px.green > top) top = px.green;
      if (px.blue > top) top = px.blue;
      if (px.green < bottom) bottom = px.green;
      if (px.blue < bottom) bottom = px.blue;
      spread = top - bottom;
      angle  = 0;
      res.brightness = COMP_W'(top);
      res.saturation = (top == 0) ? '0 : COMP_W'((spread * int'(SAT_SCALE)) / top);
      if (spread != 0) begin
         // red beats green, green beats blue on ties
         if (px.red == top) begin
            slope = int'(px.green) - int'(px.blue);
            base  = 0;
         end else if (px.green == top) begin
            slope = int'(px.blue) - int'(px.red);
            base  = int'(HUE_GREEN_OFF);
         end else begin
            slope = int'(px.red) - int'(px.green);
            base  = int'(HUE_BLUE_OFF);
         end
         angle = base + (int'(HUE_SIXTH) * slope) / spread;
         if (angle < 0) angle += int'(HUE_FULL);
         if (angle >= int'(HUE_FULL)) angle -= int'(HUE_FULL);
      end
      res.hue = HUE_W'(angle);
      return res;
   endfunction

   task automatic report_mismatch(input string text);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, text);
   endtask

   task automatic offer_pixel(input pixel_type px, input hsv_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         case ($urandom_range(0, 7))
            0, 1:    gap = 0;
            2:       gap = $urandom_range(20, 40);
            default: gap = $urandom_range(1, 12);
         endcase
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.red   <= px.red;
      req_if.green <= px.green;
      req_if.blue  <= px.blue;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_hsv.push_back(want);
   endtask

   function automatic logic [COMP_W-1:0] extreme_level();
      case ($urandom_range(0, 3))
         0:       return 8'd0;
         1:       return 8'd1;
         2:       return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: shifting stall pattern, one long hold-off to back up the pipe
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) pixels_taken <= pixels_taken + 1;
      if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!hold_done && pixels_taken >= HOLD_AT) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         hold_done    <= 1'b1;
      end else begin
         rsp_if.ready <= stall_pattern[0];
         if (pattern_left == 0) begin
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
            pattern_left  <= $urandom_range(16, 128);
         end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            pattern_left  <= pattern_left - 1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      hsv_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_hsv.size() == 0) begin
            report_mismatch($sformatf("unexpected item hue %0d sat %0d val %0d",
                                      rsp_if.hue, rsp_if.saturation, rsp_if.brightness));
         end else begin
            want = expected_hsv.pop_front();
            if (rsp_if.hue !== want.hue)
               report_mismatch($sformatf("hue got %0d expected %0d", rsp_if.hue, want.hue));
            if (rsp_if.saturation !== want.saturation)
               report_mismatch($sformatf("saturation got %0d expected %0d",
                                         rsp_if.saturation, want.saturation));
            if (rsp_if.brightness !== want.brightness)
               report_mismatch($sformatf("brightness got %0d expected %0d",
                                         rsp_if.brightness, want.brightness));
         end
      end
   end

   initial begin
      pixel_type   px;
      logic [7:0]  top_level;
      logic [7:0]  low_level;
      int          spot;
      clock        = 1'b0;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.red   = '0;
      req_if.green = '0;
      req_if.blue  = '0;
      rsp_if.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_pixel(directed_rows[i].px, directed_rows[i].typed ? directed_rows[i].golden
                                                                : hsv_of(directed_rows[i].px));

      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         case ($urandom_range(0, 9))
            5: begin
               px.red   = 8'($urandom);
               px.green = px.red;
               px.blue  = px.red;
            end
            6: begin
               // two components tie at the maximum
               top_level = 8'($urandom_range(1, 255));
               low_level = 8'($urandom_range(0, top_level - 1));
               spot      = $urandom_range(0, 2);
               px.red    = (spot == 0) ? low_level : top_level;
               px.green  = (spot == 1) ? low_level : top_level;
               px.blue   = (spot == 2) ? low_level : top_level;
            end
            7: begin
               px.red   = extreme_level();
               px.green = extreme_level();
               px.blue  = extreme_level();
            end
            8: begin
               // small spread: stress quotient truncation
               low_level = 8'($urandom_range(0, 249));
               px.red    = low_level + 8'($urandom_range(0, 6));
               px.green  = low_level + 8'($urandom_range(0, 6));
               px.blue   = low_level + 8'($urandom_range(0, 6));
            end
            9: begin
               spot     = $urandom_range(0, 2);
               px.red   = (spot == 0) ? 8'd255 : 8'($urandom);
               px.green = (spot == 1) ? 8'd255 : ((spot == 0) ? 8'd0 : 8'($urandom));
               px.blue  = (spot == 2) ? 8'd255 : ((spot == 1) ? 8'd0 : 8'd0);
               if (spot == 2) px.red = 8'd0;
            end
            default: begin
               px.red   = 8'($urandom);
               px.green = 8'($urandom);
               px.blue  = 8'($urandom);
            end
         endcase
         offer_pixel(px, hsv_of(px));
      end
      req_if.valid <= 1'b0;

      while (expected_hsv.size() != 0) @(posedge clock);
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
